[hw/rtl/opl_pkg.sv]
// Shared constants, codes and types of the ordered point list engine.
package opl_pkg;

    // List capacity and the widths that follow from it.
    localparam int MAX_ENTRIES = 64;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W       = (CNT_W > 8) ? CNT_W : 8;

    // Field widths of the request and response words.
    localparam int FUNC_W   = 3;
    localparam int COORD_W  = 8;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 7;
    localparam int PT_W     = 2 * COORD_W;

    // Operation codes.
    typedef enum logic [FUNC_W-1:0] {
        FN_APPEND = 3'd0,
        FN_DELETE = 3'd1,
        FN_INSERT = 3'd2,
        FN_LENGTH = 3'd3,
        FN_READ   = 3'd4
    } t_func;

    // Response status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } t_status;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DEL,
        S_INS,
        S_RD,
        S_DONE
    } t_state;

endpackage

[hw/rtl/opl_if.sv]
// Request and response channel interfaces of the ordered point list engine.
interface opl_req_if
    import opl_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic [COORD_W-1:0]       point_x;
    logic [COORD_W-1:0]       point_y;
    logic signed [POS_W-1:0]  position;

    modport source (output valid, func, point_x, point_y, position, input ready);
    modport sink   (input valid, func, point_x, point_y, position, output ready);
endinterface

interface opl_rsp_if
    import opl_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [LEN_W-1:0]     length;
    logic [COORD_W-1:0]   read_x;
    logic [COORD_W-1:0]   read_y;

    modport source (output valid, status, length, read_x, read_y, input ready);
    modport sink   (input valid, status, length, read_x, read_y, output ready);
endinterface

[hw/rtl/opl_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
module opl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/ordered_point_list_engine_core.sv]
// Ordered point list engine: a bounded list of (x,y) points held in a RAM.
//
// Requests arrive as words on i_req (func, point_x, point_y, position) and
// each one gives exactly one response word on o_rsp (status, length,
// read_x, read_y). A word moves when valid and ready are both high.
// One request is worked on at a time; i_req.ready is high only while the
// sequencer is idle.
// Each request is worked through in turn: append, length and any rejected
// request go straight to the response; read waits for the RAM's registered
// read; delete reads every entry once through the RAM's single read port,
// comparing and shifting down behind the match; insert shifts the tail up
// one entry per cycle, or shifts nothing when the point goes at the end.
// The response word appears in the same cycle in which the sequencer is
// idle again and the next request can be taken.
// A finished response sits in the output register until it is taken; the
// next request is accepted meanwhile, and its own response waits in the
// sequencer if the receiver is still stalling.
// Synchronous reset empties the list and drops any pending response; the
// RAM contents are not cleared, as only entries below the count are read.
module ordered_point_list_engine_core
    import opl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    opl_req_if.sink   i_req,
    opl_rsp_if.source o_rsp
);

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic [CNT_W-1:0]    r_pos, n_pos;
    logic [PT_W-1:0]     r_pt, n_pt;
    logic                r_rd_vld, n_rd_vld;
    logic [ADDR_W-1:0]   r_rd_addr, n_rd_addr;
    logic                r_found, n_found;
    t_status             r_status, n_status;
    logic [COORD_W-1:0]  r_rx, n_rx;
    logic [COORD_W-1:0]  r_ry, n_ry;
    logic                r_out_vld, n_out_vld;
    logic [STATUS_W-1:0] r_out_status;
    logic [LEN_W-1:0]    r_out_len;
    logic [COORD_W-1:0]  r_out_x, r_out_y;

    logic              req_fire, full, pos_ok, del_end, ins_end, out_free, out_load;
    logic [PT_W-1:0]   pt_in;
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [PT_W-1:0]   ram_wdata, ram_rdata;

    // Point table.
    opl_ram #(
        .WIDTH (PT_W),
        .DEPTH (MAX_ENTRIES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Handshake and request decode helpers.
    assign i_req.ready = (r_state == S_IDLE);
    assign req_fire    = i_req.valid && i_req.ready;
    assign pt_in       = {i_req.point_x, i_req.point_y};
    assign full        = (r_count == CNT_W'(MAX_ENTRIES));
    assign pos_ok      = !i_req.position[POS_W-1] && (i_req.position != '0)
                         && (CMP_W'(i_req.position[POS_W-2:0]) <= CMP_W'(r_count));
    assign del_end     = (r_idx == r_count) && !r_rd_vld;
    assign ins_end     = (r_idx == r_pos) && !r_rd_vld;
    assign out_free    = !r_out_vld || o_rsp.ready;
    assign out_load    = (r_state == S_DONE) && out_free;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    case (i_req.func)
                        FN_DELETE: n_state = S_DEL;
                        FN_INSERT: n_state = (!full && pos_ok) ? S_INS : S_DONE;
                        FN_READ:   n_state = pos_ok ? S_RD : S_DONE;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_DEL:   if (del_end) n_state = S_DONE;
            S_INS:   if (ins_end) n_state = S_DONE;
            S_RD:    n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and RAM control of the sequencer.
    always_comb begin
        n_count   = r_count;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_pt      = r_pt;
        n_rd_vld  = 1'b0;
        n_rd_addr = r_rd_addr;
        n_found   = r_found;
        n_status  = r_status;
        n_rx      = r_rx;
        n_ry      = r_ry;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = r_pt;
        ram_re    = 1'b0;
        ram_raddr = '0;
        case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_pt     = pt_in;
                    n_rx     = '0;
                    n_ry     = '0;
                    n_status = ST_OK;
                    n_idx    = '0;
                    n_found  = 1'b0;
                    case (i_req.func)
                        FN_APPEND: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = r_count[ADDR_W-1:0];
                                ram_wdata = pt_in;
                                n_count   = r_count + 1'b1;
                            end
                        end
                        FN_DELETE: begin
                            n_idx = '0;
                        end
                        FN_INSERT: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else if (!pos_ok) begin
                                n_status = ST_BAD;
                            end else begin
                                n_idx = r_count;
                                n_pos = CNT_W'(i_req.position[POS_W-2:0]);
                            end
                        end
                        FN_LENGTH: begin
                            n_status = ST_OK;
                        end
                        FN_READ: begin
                            if (!pos_ok) begin
                                n_status = ST_BAD;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = ADDR_W'(i_req.position[POS_W-2:0] - 1'b1);
                            end
                        end
                        default: begin
                            n_status = ST_BAD;
                        end
                    endcase
                end
            end
            S_DEL: begin
                // Read every entry in turn; behind the match, move each one down.
                if (r_idx < r_count) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_idx[ADDR_W-1:0];
                    n_rd_vld  = 1'b1;
                    n_rd_addr = r_idx[ADDR_W-1:0];
                    n_idx     = r_idx + 1'b1;
                end
                if (r_rd_vld) begin
                    if (r_found) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_rd_addr - 1'b1;
                        ram_wdata = ram_rdata;
                    end else if (ram_rdata == r_pt) begin
                        n_found = 1'b1;
                    end
                end
                if (del_end) begin
                    if (r_found) begin
                        n_count = r_count - 1'b1;
                    end else begin
                        n_status = ST_BAD;
                    end
                end
            end
            S_INS: begin
                // Move the tail up one entry per cycle, then drop the point in.
                if (ins_end) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_pos[ADDR_W-1:0];
                    ram_wdata = r_pt;
                    n_count   = r_count + 1'b1;
                end else begin
                    if (r_idx > r_pos) begin
                        ram_re    = 1'b1;
                        ram_raddr = ADDR_W'(r_idx - 1'b1);
                        n_rd_vld  = 1'b1;
                        n_rd_addr = ADDR_W'(r_idx - 1'b1);
                        n_idx     = r_idx - 1'b1;
                    end
                    if (r_rd_vld) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_rd_addr + 1'b1;
                        ram_wdata = ram_rdata;
                    end
                end
            end
            S_RD: begin
                n_rx = ram_rdata[PT_W-1:COORD_W];
                n_ry = ram_rdata[COORD_W-1:0];
            end
            S_DONE: begin
                n_status = r_status;
            end
            default: begin
                n_status = r_status;
            end
        endcase
    end

    // Output register valid.
    always_comb begin
        if (out_load) begin
            n_out_vld = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_rd_vld  <= 1'b0;
            r_found   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_rd_vld  <= n_rd_vld;
            r_found   <= n_found;
            r_out_vld <= n_out_vld;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_pos     <= n_pos;
        r_pt      <= n_pt;
        r_rd_addr <= n_rd_addr;
        r_status  <= n_status;
        r_rx      <= n_rx;
        r_ry      <= n_ry;
        if (out_load) begin
            r_out_status <= r_status;
            r_out_len    <= LEN_W'(r_count);
            r_out_x      <= r_rx;
            r_out_y      <= r_ry;
        end
    end

    assign o_rsp.valid  = r_out_vld;
    assign o_rsp.status = r_out_status;
    assign o_rsp.length = r_out_len;
    assign o_rsp.read_x = r_out_x;
    assign o_rsp.read_y = r_out_y;

    // The count never exceeds the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ENTRIES))
        else $error("entry count beyond capacity");

    // An accepted request always leaves the idle state.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_fire |=> r_state != S_IDLE)
        else $error("request accepted but sequencer stayed idle");

    // The table is never written while a read result or response is pending.
    a_no_late_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state != S_RD) && (r_state != S_DONE))
        else $error("table written outside an updating operation");

    // A successful delete removes exactly one entry.
    a_del_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEL) && del_end && r_found |=> r_count == $past(r_count) - 1'b1)
        else $error("delete did not shorten the list by one");

    // A new response is loaded only when the output register is free.
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !o_rsp.ready |-> !out_load)
        else $error("pending response overwritten");

endmodule
